// ----- rtl/lbe_pkg.sv -----
package lbe_pkg;

   localparam int DATA_WIDTH      = 8;
   localparam int PARITY_WIDTH    = 4;
   localparam int NUM_MASKS       = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [DATA_WIDTH-1:0]   mask_type;
   typedef logic [PARITY_WIDTH-1:0] nibble_type;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_MASK_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_MASK_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_MASK_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_MASK_3 = 3'd3;

   localparam mask_type MASK_0_RESET = 8'hEE;
   localparam mask_type MASK_1_RESET = 8'hD9;
   localparam mask_type MASK_2_RESET = 8'hB4;
   localparam mask_type MASK_3_RESET = 8'h73;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_byte;
      logic                  end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] code_byte;
      logic                  last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      mask_type mask_0;
      mask_type mask_1;
      mask_type mask_2;
      mask_type mask_3;
   } mask_set_type;

endpackage

// ----- rtl/lbe_parity.sv -----
module lbe_parity (
   input  logic [lbe_pkg::DATA_WIDTH-1:0] data_byte,
   input  lbe_pkg::mask_set_type          masks,
   output lbe_pkg::nibble_type            parity
);
   import lbe_pkg::*;

   // first mask lands in the most significant parity bit
   always_comb begin
      parity[3] = ^(data_byte & masks.mask_0);
      parity[2] = ^(data_byte & masks.mask_1);
      parity[1] = ^(data_byte & masks.mask_2);
      parity[0] = ^(data_byte & masks.mask_3);
   end

endmodule

// ----- rtl/linear_block_encoder_12_8_packer.sv -----
// channel | ports                              | transfer when
// --------+------------------------------------+----------------------------
// input   | req_valid, req_stall, req_payload  | req_valid && !req_stall
// result  | rsp_valid, rsp_stall, rsp_payload  | rsp_valid && !rsp_stall
// config  | csr_we, csr_index, csr_wdata       | csr_we
//
// An item waits in the input register, then loads the result buffer when it has room.
// Each item gives one or two result bytes, drained one per cycle, while rsp_stall is
// low, from the two-slot result buffer, so the rate is one item per cycle for one-byte
// items; a two-byte item holds the next item back until its first byte has gone.
// Synchronous reset restores the parity masks and clears the residue.
// A stalled result holds the buffer; the input stalls while its register is full and cannot load.
module linear_block_encoder_12_8_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lbe_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lbe_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_we,
   input  logic [lbe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lbe_pkg::DATA_WIDTH-1:0]       csr_wdata
);
   import lbe_pkg::*;

   mask_set_type    masks_ff, masks_in;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   nibble_type      residue_bits_ff, residue_bits_in;
   logic            residue_valid_ff, residue_valid_in;
   rsp_payload_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]      count_ff, count_in;

   nibble_type      parity;
   logic            req_xfer, rsp_xfer, load;
   rsp_payload_type new0, new1;
   logic [1:0]      new_count;

   lbe_parity u_parity (
      .data_byte (in_data_ff.data_byte),
      .masks     (masks_ff),
      .parity    (parity)
   );

   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign load      = in_valid_ff && (count_ff == 2'd0 || (count_ff == 2'd1 && rsp_xfer));
   assign req_stall = in_valid_ff && !load;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_payload = slot0_ff;

   always_comb begin
      masks_in = masks_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PARITY_MASK_0: masks_in.mask_0 = csr_wdata;
            CSR_PARITY_MASK_1: masks_in.mask_1 = csr_wdata;
            CSR_PARITY_MASK_2: masks_in.mask_2 = csr_wdata;
            CSR_PARITY_MASK_3: masks_in.mask_3 = csr_wdata;
            default:           masks_in = masks_ff;
         endcase
      end
   end

   // packing of one codeword against the pending residue
   always_comb begin
      residue_bits_in  = residue_bits_ff;
      residue_valid_in = residue_valid_ff;
      new1.code_byte   = {parity, 4'b0000};
      new1.last_of_run = 1'b1;
      if (residue_valid_ff) begin
         new0.code_byte   = {residue_bits_ff, in_data_ff.data_byte[7:4]};
         new0.last_of_run = 1'b0;
         new1.code_byte   = {in_data_ff.data_byte[3:0], parity};
         new_count        = 2'd2;
         residue_bits_in  = '0;
         residue_valid_in = 1'b0;
      end else if (in_data_ff.end_of_stream) begin
         // flush the parity nibble zero-filled
         new0.code_byte   = in_data_ff.data_byte;
         new0.last_of_run = 1'b0;
         new_count        = 2'd2;
         residue_bits_in  = '0;
         residue_valid_in = 1'b0;
      end else begin
         new0.code_byte   = in_data_ff.data_byte;
         new0.last_of_run = 1'b1;
         new_count        = 2'd1;
         residue_bits_in  = parity;
         residue_valid_in = 1'b1;
      end
      if (!load) begin
         residue_bits_in  = residue_bits_ff;
         residue_valid_in = residue_valid_ff;
      end
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (load) begin
         slot0_in = new0;
         slot1_in = new1;
         count_in = new_count;
      end else if (rsp_xfer) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   assign in_valid_in = req_xfer ? 1'b1 : (load ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff         <= '{MASK_0_RESET, MASK_1_RESET, MASK_2_RESET, MASK_3_RESET};
         in_valid_ff      <= 1'b0;
         residue_bits_ff  <= '0;
         residue_valid_ff <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         masks_ff         <= masks_in;
         in_valid_ff      <= in_valid_in;
         residue_bits_ff  <= residue_bits_in;
         residue_valid_ff <= residue_valid_in;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_payload;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending input item lost");

   a_residue_used: assert property (@(posedge clock) disable iff (reset)
      load && residue_valid_ff |=> !residue_valid_ff && count_ff == 2'd2)
      else $error("residue not consumed as two result bytes");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded item gives no result");
`endif

endmodule
